[sv/chht_pkg.sv]
// Shared types and constants for the colour histogram hash table unit.
// Command and status structs between controller and datapath, field widths, codes.
// No dependencies.
`timescale 1ns / 1ps

package chht_pkg;

  // Default table geometry and count width
  localparam int TABLE_SIZE_DEF = 8192;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths of the ports
  localparam int MODE_W     = 2;
  localparam int COLOR_W    = 8;
  localparam int KEY_W      = 3 * COLOR_W;
  localparam int SLOT_IN_W  = 13;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 13;
  localparam int OUT_CNT_W  = 32;
  localparam int USED_W     = 14;
  localparam int LIMIT_W    = 14;

  // Reset value of the load limit register
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 14'd6144;

  // Hash weights and the width of the raw hash (61 * 255 fits in 14 bits)
  localparam int HASH_W     = 14;
  localparam int HASH_MUL_R = 23;
  localparam int HASH_MUL_G = 21;
  localparam int HASH_MUL_B = 17;

  // Operation codes on the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_NEW     = 3'd0,
    STATUS_RAISED  = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_READ    = 3'd3,
    STATUS_CLEARED = 3'd4
  } status_e;

  // Which result the datapath builds when the output register loads
  typedef enum logic [1:0] {
    OUT_HIT,
    OUT_FULL,
    OUT_READ,
    OUT_CLEAR
  } out_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      load_in;
    logic      sel_hash;
    logic      calc_quot;
    logic      issue_home;
    logic      issue_next;
    logic      write_hit;
    logic      clr_step;
    logic      load_out;
    out_kind_e out_kind;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_empty;
    logic slot_match;
    logic probe_last;
    logic clr_last;
  } sts_t;

endpackage

[sv/chht_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone, no package dependency.
`timescale 1ns / 1ps

module chht_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read word; hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/chht_dp.sv]
// Datapath of the colour histogram hash table: hash, home slot reduction, probe
// addressing, table RAM, occupancy, load limit and the output register.
// Depends on chht_pkg and chht_ram.
`timescale 1ns / 1ps

module chht_dp #(
  parameter int TABLE_SIZE = chht_pkg::TABLE_SIZE_DEF,
  parameter int COUNT_BITS = chht_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  chht_pkg::cmd_t                 cmd_i,
  output chht_pkg::sts_t                 sts_o,
  input  logic [chht_pkg::COLOR_W-1:0]   red_i,
  input  logic [chht_pkg::COLOR_W-1:0]   green_i,
  input  logic [chht_pkg::COLOR_W-1:0]   blue_i,
  input  logic [chht_pkg::SLOT_IN_W-1:0] slot_index_i,
  input  logic                           cfg_we_i,
  input  logic [chht_pkg::LIMIT_W-1:0]   load_limit_i,
  output logic [chht_pkg::STATUS_W-1:0]  status_o,
  output logic [chht_pkg::SLOT_W-1:0]    slot_o,
  output logic [chht_pkg::COLOR_W-1:0]   slot_red_o,
  output logic [chht_pkg::COLOR_W-1:0]   slot_green_o,
  output logic [chht_pkg::COLOR_W-1:0]   slot_blue_o,
  output logic [chht_pkg::OUT_CNT_W-1:0] slot_count_o,
  output logic [chht_pkg::USED_W-1:0]    used_slots_o,
  output logic                           over_limit_o
);

  import chht_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int STEP_W  = $clog2(TABLE_SIZE + 1);
  localparam int OCC_W   = STEP_W;
  localparam int ENTRY_W = KEY_W + COUNT_BITS;
  // Reciprocal for an exact quotient of any HASH_W-bit value by TABLE_SIZE
  localparam int SHIFT   = HASH_W + IDX_W;
  localparam int RECIP_W = HASH_W + 2;
  localparam int PROD_W  = HASH_W + RECIP_W;
  localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);

  logic [KEY_W-1:0]      key_q;
  logic [HASH_W-1:0]     h_q;
  logic [HASH_W-1:0]     q_q;
  logic [IDX_W-1:0]      pos_q;
  logic [STEP_W-1:0]     step_q;
  logic [IDX_W-1:0]      clr_addr_q;
  logic [OCC_W-1:0]      occ_q, occ_d;
  logic [LIMIT_W-1:0]    load_limit_q;

  logic [STATUS_W-1:0]   status_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [KEY_W-1:0]      color_q;
  logic [OUT_CNT_W-1:0]  count_q;
  logic [USED_W-1:0]     used_q;
  logic                  over_q;

  logic [HASH_W-1:0]     hash;
  logic [PROD_W-1:0]     prod;
  logic [31:0]           rem_full;
  logic [IDX_W-1:0]      home_pos;
  logic [IDX_W:0]        pos_sum;
  logic [IDX_W:0]        pos_wrap;
  logic [IDX_W-1:0]      next_pos;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [COUNT_BITS-1:0] cnt_rd, cnt_new;
  logic [KEY_W-1:0]      color_rd;
  logic                  slot_empty;

  // Hash of the incoming colour
  assign hash = HASH_W'(HASH_MUL_R) * HASH_W'(red_i)
              + HASH_W'(HASH_MUL_G) * HASH_W'(green_i)
              + HASH_W'(HASH_MUL_B) * HASH_W'(blue_i);

  // Quotient by reciprocal multiply, then the remainder is the home slot
  assign prod     = PROD_W'(h_q) * PROD_W'(RECIP);
  assign rem_full = 32'(h_q) - 32'(q_q) * 32'(TABLE_SIZE);
  assign home_pos = rem_full[IDX_W-1:0];

  // Next probe position: one wrap at most since pos and step stay below TABLE_SIZE
  assign pos_sum  = {1'b0, pos_q} + (IDX_W+1)'(step_q);
  assign pos_wrap = pos_sum - (IDX_W+1)'(TABLE_SIZE);
  assign next_pos = (pos_sum >= (IDX_W+1)'(TABLE_SIZE)) ? pos_wrap[IDX_W-1:0]
                                                         : pos_sum[IDX_W-1:0];

  // Decode the word read from the table
  assign cnt_rd     = ram_rdata[COUNT_BITS-1:0];
  assign color_rd   = ram_rdata[ENTRY_W-1:COUNT_BITS];
  assign slot_empty = (cnt_rd == '0);
  assign cnt_new    = slot_empty ? COUNT_BITS'(1)
                    : ((&cnt_rd) ? cnt_rd : cnt_rd + COUNT_BITS'(1));

  // Table port selection: clearing sweep or write back, home or next probe read
  always_comb begin
    ram_we    = cmd_i.clr_step | cmd_i.write_hit;
    ram_waddr = cmd_i.clr_step ? clr_addr_q : pos_q;
    ram_wdata = cmd_i.clr_step ? '0 : {key_q, cnt_new};
    ram_re    = cmd_i.issue_home | cmd_i.issue_next;
    ram_raddr = cmd_i.issue_home ? home_pos : next_pos;
  end

  chht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Occupancy after this cycle
  always_comb begin
    occ_d = occ_q;
    if (cmd_i.clr_step) begin
      occ_d = '0;
    end else if (cmd_i.write_hit && slot_empty) begin
      occ_d = occ_q + OCC_W'(1);
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.slot_empty = slot_empty;
    sts_o.slot_match = (color_rd == key_q);
    sts_o.probe_last = (step_q == STEP_W'(TABLE_SIZE));
    sts_o.clr_last   = (clr_addr_q == IDX_W'(TABLE_SIZE - 1));
  end

  // Control registers: sweep address, occupancy, load limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      occ_q        <= '0;
      load_limit_q <= LOAD_LIMIT_RESET;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.clr_step) begin
        clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + IDX_W'(1);
      end
      if (cfg_we_i) begin
        load_limit_q <= load_limit_i;
      end
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q <= {red_i, green_i, blue_i};
      h_q   <= cmd_i.sel_hash ? hash : HASH_W'(slot_index_i);
    end
    if (cmd_i.calc_quot) begin
      q_q <= HASH_W'(prod >> SHIFT);
    end
    if (cmd_i.issue_home) begin
      pos_q  <= home_pos;
      step_q <= STEP_W'(1);
    end else if (cmd_i.issue_next) begin
      pos_q  <= next_pos;
      step_q <= step_q + STEP_W'(1);
    end
  end

  // Output register: build the result the controller asks for
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      used_q <= USED_W'(occ_d);
      over_q <= (32'(occ_d) > 32'(load_limit_q));
      case (cmd_i.out_kind)
        OUT_HIT: begin
          status_q <= slot_empty ? STATUS_NEW : STATUS_RAISED;
          slot_q   <= SLOT_W'(pos_q);
          color_q  <= key_q;
          count_q  <= OUT_CNT_W'(cnt_new);
        end
        OUT_READ: begin
          status_q <= STATUS_READ;
          slot_q   <= SLOT_W'(pos_q);
          color_q  <= color_rd;
          count_q  <= OUT_CNT_W'(cnt_rd);
        end
        OUT_FULL: begin
          status_q <= STATUS_FULL;
          slot_q   <= '0;
          color_q  <= '0;
          count_q  <= '0;
        end
        default: begin
          status_q <= STATUS_CLEARED;
          slot_q   <= '0;
          color_q  <= '0;
          count_q  <= '0;
        end
      endcase
    end
  end

  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign slot_red_o   = color_q[KEY_W-1 -: COLOR_W];
  assign slot_green_o = color_q[COLOR_W +: COLOR_W];
  assign slot_blue_o  = color_q[COLOR_W-1:0];
  assign slot_count_o = count_q;
  assign used_slots_o = used_q;
  assign over_limit_o = over_q;

  // The reduced home slot always lies inside the table
  a_home_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_home |-> (rem_full < 32'(TABLE_SIZE)))
    else $error("home slot outside the table");

  // Occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(TABLE_SIZE))
    else $error("occupancy above table size");

  // Clearing sweep and write back never share the write port
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_step && cmd_i.write_hit))
    else $error("two writers on the table port");

endmodule

[sv/chht_ctrl.sv]
// Controller of the colour histogram hash table: sequences hash reduction, probing,
// reads, clearing sweeps and the output handshake.
// Depends on chht_pkg.
`timescale 1ns / 1ps

module chht_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [chht_pkg::MODE_W-1:0] mode_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output chht_pkg::cmd_t              cmd_o,
  input  chht_pkg::sts_t              sts_i
);

  import chht_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_QUOT,
    ST_HOME,
    ST_PROBE,
    ST_READ,
    ST_CLR,
    ST_CLR_DONE
  } state_e;

  state_e state_q, state_d;
  logic   op_read_q, op_read_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;
  logic   start_read;

  // The output register can take a result when empty or being emptied now
  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    op_read_d  = op_read_q;
    cmd_o      = '0;
    start_read = 1'b0;

    case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_COUNT: begin
              cmd_o.load_in  = 1'b1;
              cmd_o.sel_hash = 1'b1;
              op_read_d      = 1'b0;
              state_d        = ST_QUOT;
            end
            MODE_CLEAR: begin
              state_d = ST_CLR;
            end
            MODE_READ: begin
              start_read = 1'b1;
            end
            default: begin
              start_read = 1'b1;
            end
          endcase
          if (start_read) begin
            cmd_o.load_in = 1'b1;
            op_read_d     = 1'b1;
            state_d       = ST_QUOT;
          end
        end
      end
      ST_QUOT: begin
        cmd_o.calc_quot = 1'b1;
        state_d         = ST_HOME;
      end
      ST_HOME: begin
        cmd_o.issue_home = 1'b1;
        state_d          = op_read_q ? ST_READ : ST_PROBE;
      end
      ST_PROBE: begin
        if (sts_i.slot_empty || sts_i.slot_match) begin
          if (can_load) begin
            cmd_o.write_hit = 1'b1;
            cmd_o.load_out  = 1'b1;
            cmd_o.out_kind  = OUT_HIT;
            state_d         = ST_IDLE;
          end
        end else if (sts_i.probe_last) begin
          if (can_load) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_kind = OUT_FULL;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.issue_next = 1'b1;
        end
      end
      ST_READ: begin
        if (can_load) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = OUT_READ;
          state_d        = ST_IDLE;
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_CLR_DONE;
        end
      end
      ST_CLR_DONE: begin
        if (can_load) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = OUT_CLEAR;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output valid: set on load, drop once the transaction is taken
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      op_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_read_q   <= op_read_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten");

  // Write back only on an empty or matching slot
  a_write_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_hit |-> (sts_i.slot_empty || sts_i.slot_match))
    else $error("write back without a hit");

  // The home read is always followed by its evaluation
  a_home_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOME) |=> (state_q == ST_READ || state_q == ST_PROBE))
    else $error("home read not evaluated");

endmodule

[sv/color_histogram_hash_table_unit.sv]
// Colour histogram in an open-addressed hash table with quadratic-step probing.
// After reset the table RAM is swept clear, one slot per cycle; inputs stall during
// that pass, configuration writes are taken at any time. Counting a colour loads the
// input, reduces its hash to a home slot (quotient, then remainder), reads the home
// slot and then reads one further slot for every further probe, up to TABLE_SIZE
// probes (8192 by default) when the table is full; a read stops after the home slot
// and a clear sweeps every slot before its result. The sequence follows from the
// registered read of the single-read-port table RAM, the quotient and remainder steps
// of the reduction and the one-slot-a-cycle clearing sweep. A finished result waits
// in the output register while the next transaction is accepted.
`timescale 1ns / 1ps

module color_histogram_hash_table_unit #(
  parameter int TABLE_SIZE = chht_pkg::TABLE_SIZE_DEF,
  parameter int COUNT_BITS = chht_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input transactions
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [chht_pkg::MODE_W-1:0]    mode_i,
  input  logic [chht_pkg::COLOR_W-1:0]   red_i,
  input  logic [chht_pkg::COLOR_W-1:0]   green_i,
  input  logic [chht_pkg::COLOR_W-1:0]   blue_i,
  input  logic [chht_pkg::SLOT_IN_W-1:0] slot_index_i,
  // Result transactions
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [chht_pkg::STATUS_W-1:0]  status_o,
  output logic [chht_pkg::SLOT_W-1:0]    slot_o,
  output logic [chht_pkg::COLOR_W-1:0]   slot_red_o,
  output logic [chht_pkg::COLOR_W-1:0]   slot_green_o,
  output logic [chht_pkg::COLOR_W-1:0]   slot_blue_o,
  output logic [chht_pkg::OUT_CNT_W-1:0] slot_count_o,
  output logic [chht_pkg::USED_W-1:0]    used_slots_o,
  output logic                           over_limit_o,
  // Load limit register write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [chht_pkg::LIMIT_W-1:0]   load_limit_i
);

  import chht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The register is always writable
  assign cfg_ready_o = 1'b1;

  chht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  chht_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .slot_index_i (slot_index_i),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .load_limit_i (load_limit_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .slot_red_o   (slot_red_o),
    .slot_green_o (slot_green_o),
    .slot_blue_o  (slot_blue_o),
    .slot_count_o (slot_count_o),
    .used_slots_o (used_slots_o),
    .over_limit_o (over_limit_o)
  );

endmodule
